@@ hw/rtl/ufr_pkg.sv @@
// Package with the types, codes and helper functions of the update frame receiver.
`default_nettype none
package ufr_pkg;

    localparam logic [7:0] BYTE_START     = 8'h0F;
    localparam logic [7:0] BYTE_END       = 8'hF0;
    localparam logic [7:0] BYTE_ACK       = 8'h79;
    localparam logic [7:0] BYTE_NACK      = 8'h7F;
    localparam logic [7:0] BYTE_WORD_OK   = 8'h69;
    localparam logic [7:0] BYTE_FRAMES_OK = 8'h77;
    localparam logic [7:0] HDR_DATA       = 8'h00;
    localparam logic [7:0] HDR_CRC        = 8'h06;
    localparam logic [7:0] HDR_LEN        = 8'h07;
    localparam logic [7:0] HDR_FRAMES     = 8'h08;

    localparam logic [31:0] LENGTH_RESET  = 32'h0403_0201;
    localparam logic        KIND_REPLY    = 1'b0;
    localparam logic        KIND_PAYLOAD  = 1'b1;
    localparam int          TDATA_W       = 152;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_DATA   = 5'b00010,
        PH_CRC    = 5'b00100,
        PH_LEN    = 5'b01000,
        PH_FRAMES = 5'b10000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [7:0]  payload_index;
        logic [15:0] frame_offset;
        logic [15:0] accepted_frames;
        logic [31:0] program_crc;
        logic [31:0] program_length;
        logic [31:0] program_frames;
        logic        session_active;
        logic        end_seen;
    } t_result;

    function automatic logic [7:0] word_xor(input logic [31:0] w);
        return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (pos)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ufr_core.sv @@
// Frame parser state and per-byte result logic of the update frame receiver.
`default_nettype none
module ufr_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  wire  [7:0]           i_byte,
    output logic                 o_res_valid,
    output ufr_pkg::t_result     o_res
);

    ufr_pkg::t_phase r_phase, n_phase;
    logic [8:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_offset, n_offset;
    logic        r_active, n_active;
    logic        r_end, n_end;
    logic [15:0] r_frames_cnt, n_frames_cnt;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_length, n_length;
    logic [31:0] r_fwords, n_fwords;

    logic        w_valid;
    logic        w_kind;
    logic [7:0]  w_byte;
    logic [7:0]  w_index;
    logic [31:0] w_word;
    logic [8:0]  w_data_end;

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_len        = r_len;
        n_xor        = r_xor;
        n_offset     = r_offset;
        n_active     = r_active;
        n_end        = r_end;
        n_frames_cnt = r_frames_cnt;
        n_crc        = r_crc;
        n_length     = r_length;
        n_fwords     = r_fwords;
        w_valid      = 1'b0;
        w_kind       = ufr_pkg::KIND_REPLY;
        w_byte       = ufr_pkg::BYTE_ACK;
        w_index      = 8'd0;
        w_data_end   = {1'b0, r_len} + 9'd3;
        w_word       = r_crc;

        case (r_phase)
            ufr_pkg::PH_DATA: begin
                if (r_count == 9'd0) begin
                    n_len   = i_byte;
                    n_xor   = i_byte;
                    n_count = 9'd1;
                end else if (r_count == 9'd1 || r_count == 9'd2) begin
                    if (r_count == 9'd1) begin
                        n_offset[15:8] = i_byte;
                    end else begin
                        n_offset[7:0] = i_byte;
                    end
                    n_xor   = r_xor ^ i_byte;
                    n_count = r_count + 9'd1;
                end else if (r_count < w_data_end) begin
                    n_xor   = r_xor ^ i_byte;
                    n_count = r_count + 9'd1;
                    w_valid = 1'b1;
                    w_kind  = ufr_pkg::KIND_PAYLOAD;
                    w_byte  = i_byte;
                    w_index = 8'(r_count - 9'd3);
                end else begin
                    n_phase = ufr_pkg::PH_HEADER;
                    n_count = 9'd0;
                    if (r_active) begin
                        w_valid = 1'b1;
                        if (i_byte == r_xor) begin
                            w_byte = ufr_pkg::BYTE_ACK;
                            if (r_frames_cnt != 16'hFFFF) begin
                                n_frames_cnt = r_frames_cnt + 16'd1;
                            end
                        end else begin
                            w_byte = ufr_pkg::BYTE_NACK;
                        end
                    end
                end
            end
            ufr_pkg::PH_CRC, ufr_pkg::PH_LEN, ufr_pkg::PH_FRAMES: begin
                case (r_phase)
                    ufr_pkg::PH_CRC: w_word = r_crc;
                    ufr_pkg::PH_LEN: w_word = r_length;
                    default:         w_word = r_fwords;
                endcase
                if (r_count < 9'd4) begin
                    case (r_phase)
                        ufr_pkg::PH_CRC: n_crc    = ufr_pkg::put_byte(r_crc, r_count[1:0], i_byte);
                        ufr_pkg::PH_LEN: n_length = ufr_pkg::put_byte(r_length, r_count[1:0],
                                                                      i_byte);
                        default:         n_fwords = ufr_pkg::put_byte(r_fwords, r_count[1:0],
                                                                      i_byte);
                    endcase
                    n_count = r_count + 9'd1;
                end else begin
                    n_phase = ufr_pkg::PH_HEADER;
                    n_count = 9'd0;
                    w_valid = 1'b1;
                    if (i_byte != ufr_pkg::word_xor(w_word)) begin
                        w_byte = ufr_pkg::BYTE_NACK;
                    end else if (r_phase == ufr_pkg::PH_FRAMES) begin
                        w_byte = ufr_pkg::BYTE_FRAMES_OK;
                    end else begin
                        w_byte = ufr_pkg::BYTE_WORD_OK;
                    end
                end
            end
            default: begin
                n_phase = ufr_pkg::PH_HEADER;
                n_count = 9'd0;
                case (i_byte)
                    ufr_pkg::BYTE_START: begin
                        n_active = 1'b1;
                        w_valid  = 1'b1;
                    end
                    ufr_pkg::BYTE_END: begin
                        n_active     = 1'b0;
                        n_end        = 1'b1;
                        n_frames_cnt = 16'd0;
                        w_valid      = 1'b1;
                    end
                    ufr_pkg::HDR_DATA:   n_phase = ufr_pkg::PH_DATA;
                    ufr_pkg::HDR_CRC:    n_phase = ufr_pkg::PH_CRC;
                    ufr_pkg::HDR_LEN:    n_phase = ufr_pkg::PH_LEN;
                    ufr_pkg::HDR_FRAMES: n_phase = ufr_pkg::PH_FRAMES;
                    default:             n_phase = ufr_pkg::PH_HEADER;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ufr_pkg::PH_HEADER;
            r_count      <= 9'd0;
            r_len        <= 8'd0;
            r_xor        <= 8'd0;
            r_offset     <= 16'd0;
            r_active     <= 1'b0;
            r_end        <= 1'b0;
            r_frames_cnt <= 16'd0;
            r_crc        <= 32'd0;
            r_length     <= ufr_pkg::LENGTH_RESET;
            r_fwords     <= 32'd0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_len        <= n_len;
            r_xor        <= n_xor;
            r_offset     <= n_offset;
            r_active     <= n_active;
            r_end        <= n_end;
            r_frames_cnt <= n_frames_cnt;
            r_crc        <= n_crc;
            r_length     <= n_length;
            r_fwords     <= n_fwords;
        end
    end

    assign o_res_valid = w_valid;

    always_comb begin
        o_res.kind            = w_kind;
        o_res.out_byte        = w_byte;
        o_res.payload_index   = w_index;
        o_res.frame_offset    = n_offset;
        o_res.accepted_frames = n_frames_cnt;
        o_res.program_crc     = n_crc;
        o_res.program_length  = n_length;
        o_res.program_frames  = n_fwords;
        o_res.session_active  = n_active;
        o_res.end_seen        = n_end;
    end

endmodule
`default_nettype wire

@@ hw/rtl/ufr_out_reg.sv @@
// Result register that holds one finished result until the master side takes it.
`default_nettype none
module ufr_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  wire                  i_res_valid,
    input  ufr_pkg::t_result     i_res,
    input  wire                  i_tready,
    output logic                 o_tvalid,
    output logic                 o_free,
    output ufr_pkg::t_result     o_res
);

    logic             r_valid;
    ufr_pkg::t_result r_res;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule
`default_nettype wire

@@ hw/rtl/update_frame_receiver_top.sv @@
// Top level of the update frame receiver: input register, parser core and result register.
// A byte is first captured in the input register; its result is then loaded into the result
// register, from which it is presented on the master side.
// Throughput: one byte per cycle; the parser state is updated by one pass of logic per byte.
// A stalled master side holds back the input register and then the slave side.
// Reset is synchronous and active low; it empties both registers and returns the parser
// to the header phase with the length word at 0x04030201.
`default_nettype none
module update_frame_receiver_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  wire  [7:0]                  i_s_tdata,   // [7:0] rx_byte
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [ufr_pkg::TDATA_W-1:0] o_m_tdata,   // [7:0] out_byte, [15:8] payload_index,
                                                     // [31:16] frame_offset,
                                                     // [47:32] accepted_frames,
                                                     // [79:48] program_crc,
                                                     // [111:80] program_length,
                                                     // [143:112] program_frames,
                                                     // [144] session_active, [145] end_seen,
                                                     // [151:146] zero
    output logic                        o_m_tuser    // [0] result_kind
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             w_free;
    logic             w_advance;
    logic             w_res_valid;
    ufr_pkg::t_result w_res;
    ufr_pkg::t_result w_out;

    assign w_advance  = r_in_valid && w_free;
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ufr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ufr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_tready    (i_m_tready),
        .o_tvalid    (o_m_tvalid),
        .o_free      (w_free),
        .o_res       (w_out)
    );

    assign o_m_tuser = w_out.kind;
    assign o_m_tdata = {6'd0, w_out.end_seen, w_out.session_active, w_out.program_frames,
                        w_out.program_length, w_out.program_crc, w_out.accepted_frames,
                        w_out.frame_offset, w_out.payload_index, w_out.out_byte};

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte))
        else $error("Input register lost a byte while the result side was stalled.");

    a_payload_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ufr_pkg::KIND_PAYLOAD) |-> o_m_tdata[15:8] != 8'hFF)
        else $error("Payload index out of range.");

    a_reply_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ufr_pkg::KIND_REPLY) |-> o_m_tdata[15:8] == 8'd0)
        else $error("Reply result carries a non-zero payload index.");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[145] && !o_m_tdata[144] |-> o_m_tdata[47:32] == 16'd0)
        else $error("End of session left the frame count set.");

endmodule
`default_nettype wire

@@ test/update_frame_receiver_top_tb.sv @@
// Self-checking testbench for the update frame receiver with a byte-level predictor.
`timescale 1ns / 1ps
module update_frame_receiver_top_tb;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic [7:0]                     s_data = 8'h00;
    logic                           m_ready = 1'b0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [ufr_pkg::TDATA_W-1:0]    o_m_tdata;
    logic                           o_m_tuser;

    update_frame_receiver_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    logic [7:0]          tx_bytes[$];
    ufr_pkg::t_result    due_results[$];

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned queued_items = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned acked_frames = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    ufr_pkg::t_phase rx_phase = ufr_pkg::PH_HEADER;
    logic [8:0]  rx_count = '0;
    logic [7:0]  frame_len = '0;
    logic [7:0]  frame_xor = '0;
    logic [15:0] flash_offset = '0;
    logic        session_open = 1'b0;
    logic        end_received = 1'b0;
    logic [15:0] ok_frames = '0;
    logic [31:0] crc_value = '0;
    logic [31:0] length_value = ufr_pkg::LENGTH_RESET;
    logic [31:0] frames_value = '0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic track_rx_byte(input logic [7:0] b);
        ufr_pkg::t_result r;
        logic             emit;
        logic [31:0]      w;
        r = '0;
        emit = 1'b0;
        case (rx_phase)
            ufr_pkg::PH_DATA: begin
                if (rx_count == 9'd0) begin
                    frame_len = b;
                    frame_xor = b;
                    rx_count = 9'd1;
                end else if (rx_count == 9'd1) begin
                    flash_offset[15:8] = b;
                    frame_xor = frame_xor ^ b;
                    rx_count = 9'd2;
                end else if (rx_count == 9'd2) begin
                    flash_offset[7:0] = b;
                    frame_xor = frame_xor ^ b;
                    rx_count = 9'd3;
                end else if (rx_count < 9'd3 + 9'(frame_len)) begin
                    frame_xor = frame_xor ^ b;
                    emit = 1'b1;
                    r.kind = ufr_pkg::KIND_PAYLOAD;
                    r.out_byte = b;
                    r.payload_index = 8'(rx_count - 9'd3);
                    rx_count = rx_count + 9'd1;
                end else begin
                    rx_phase = ufr_pkg::PH_HEADER;
                    rx_count = '0;
                    if (session_open) begin
                        emit = 1'b1;
                        if (b == frame_xor) begin
                            if (ok_frames != 16'hFFFF)
                                ok_frames = ok_frames + 16'd1;
                            acked_frames++;
                            r.out_byte = ufr_pkg::BYTE_ACK;
                        end else begin
                            r.out_byte = ufr_pkg::BYTE_NACK;
                        end
                    end
                end
            end
            ufr_pkg::PH_CRC, ufr_pkg::PH_LEN, ufr_pkg::PH_FRAMES: begin
                case (rx_phase)
                    ufr_pkg::PH_CRC: w = crc_value;
                    ufr_pkg::PH_LEN: w = length_value;
                    default:         w = frames_value;
                endcase
                if (rx_count < 9'd4) begin
                    w[rx_count[1:0] * 8 +: 8] = b;
                    rx_count = rx_count + 9'd1;
                    case (rx_phase)
                        ufr_pkg::PH_CRC: crc_value = w;
                        ufr_pkg::PH_LEN: length_value = w;
                        default:         frames_value = w;
                    endcase
                end else begin
                    emit = 1'b1;
                    if (b == (w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24]))
                        r.out_byte = (rx_phase == ufr_pkg::PH_FRAMES) ?
                                     ufr_pkg::BYTE_FRAMES_OK : ufr_pkg::BYTE_WORD_OK;
                    else
                        r.out_byte = ufr_pkg::BYTE_NACK;
                    rx_phase = ufr_pkg::PH_HEADER;
                    rx_count = '0;
                end
            end
            default: begin
                rx_phase = ufr_pkg::PH_HEADER;
                rx_count = '0;
                if (b == ufr_pkg::BYTE_START) begin
                    session_open = 1'b1;
                    emit = 1'b1;
                    r.out_byte = ufr_pkg::BYTE_ACK;
                end else if (b == ufr_pkg::BYTE_END) begin
                    session_open = 1'b0;
                    end_received = 1'b1;
                    ok_frames = '0;
                    emit = 1'b1;
                    r.out_byte = ufr_pkg::BYTE_ACK;
                end else if (b == ufr_pkg::HDR_DATA) begin
                    rx_phase = ufr_pkg::PH_DATA;
                end else if (b == ufr_pkg::HDR_CRC) begin
                    rx_phase = ufr_pkg::PH_CRC;
                end else if (b == ufr_pkg::HDR_LEN) begin
                    rx_phase = ufr_pkg::PH_LEN;
                end else if (b == ufr_pkg::HDR_FRAMES) begin
                    rx_phase = ufr_pkg::PH_FRAMES;
                end
            end
        endcase
        if (emit) begin
            r.frame_offset = flash_offset;
            r.accepted_frames = ok_frames;
            r.program_crc = crc_value;
            r.program_length = length_value;
            r.program_frames = frames_value;
            r.session_active = session_open;
            r.end_seen = end_received;
            due_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                track_rx_byte(s_data);
                bytes_sent++;
            end
            if (!s_valid || o_s_tready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    s_valid <= 1'b1;
                    s_data <= tx_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        ufr_pkg::t_result got;
        ufr_pkg::t_result exp_r;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = {o_m_tuser, o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[31:16],
                   o_m_tdata[47:32], o_m_tdata[79:48], o_m_tdata[111:80],
                   o_m_tdata[143:112], o_m_tdata[144], o_m_tdata[145]};
            if (due_results.size() == 0) begin
                if (fail_count < 10)
                    $display("Unexpected result transfer: kind %0d byte %h idx %0d",
                             got.kind, got.out_byte, got.payload_index);
                fail_count++;
            end else begin
                exp_r = due_results.pop_front();
                results_checked++;
                if (got !== exp_r) begin
                    if (fail_count < 10) begin
                        $display("Mismatch on result %0d", results_checked);
                        $display("  expected kind %0d byte %h idx %0d off %h frames %h",
                                 exp_r.kind, exp_r.out_byte, exp_r.payload_index,
                                 exp_r.frame_offset, exp_r.accepted_frames);
                        $display("           crc %h len %h frm %h act %0d end %0d",
                                 exp_r.program_crc, exp_r.program_length,
                                 exp_r.program_frames, exp_r.session_active,
                                 exp_r.end_seen);
                        $display("  actual   kind %0d byte %h idx %0d off %h frames %h",
                                 got.kind, got.out_byte, got.payload_index,
                                 got.frame_offset, got.accepted_frames);
                        $display("           crc %h len %h frm %h act %0d end %0d",
                                 got.program_crc, got.program_length,
                                 got.program_frames, got.session_active, got.end_seen);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_item(input logic [7:0] b);
        tx_bytes.push_back(b);
        queued_items++;
    endtask

    task automatic push_data_frame(input logic [7:0] len, input logic [15:0] offset,
                                   input bit good);
        logic [7:0] sum;
        logic [7:0] pb;
        sum = len ^ offset[15:8] ^ offset[7:0];
        push_item(ufr_pkg::HDR_DATA);
        push_item(len);
        push_item(offset[15:8]);
        push_item(offset[7:0]);
        for (int k = 0; k < len; k++) begin
            pb = 8'($urandom);
            sum = sum ^ pb;
            push_item(pb);
        end
        push_item(good ? sum : sum ^ 8'(1 << $urandom_range(7)));
    endtask

    task automatic push_word_frame(input logic [7:0] hdr, input bit good);
        logic [31:0] w;
        logic [7:0]  sum;
        w = $urandom;
        sum = w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
        push_item(hdr);
        for (int k = 0; k < 4; k++)
            push_item(w[k * 8 +: 8]);
        push_item(good ? sum : sum ^ 8'(1 << $urandom_range(7)));
    endtask

    task automatic push_random_sequence();
        int unsigned pick;
        logic [7:0]  nb;
        logic [7:0]  len;
        pick = $urandom_range(99);
        if (pick < 8) begin
            push_item(ufr_pkg::BYTE_START);
        end else if (pick < 12) begin
            push_item(ufr_pkg::BYTE_END);
        end else if (pick < 55) begin
            len = ($urandom_range(29) == 0) ? 8'($urandom_range(255, 120))
                                            : 8'($urandom_range(8));
            push_data_frame(len, 16'($urandom), $urandom_range(9) != 0);
        end else if (pick < 85) begin
            case ($urandom_range(2))
                0:       nb = ufr_pkg::HDR_CRC;
                1:       nb = ufr_pkg::HDR_LEN;
                default: nb = ufr_pkg::HDR_FRAMES;
            endcase
            push_word_frame(nb, $urandom_range(4) != 0);
        end else if (pick < 93) begin
            do
                nb = 8'($urandom);
            while (nb == ufr_pkg::BYTE_START || nb == ufr_pkg::BYTE_END ||
                   nb == ufr_pkg::HDR_DATA || nb == ufr_pkg::HDR_CRC ||
                   nb == ufr_pkg::HDR_LEN || nb == ufr_pkg::HDR_FRAMES);
            push_item(nb);
        end else begin
            len = 8'($urandom_range(6, 1));
            push_item(ufr_pkg::HDR_DATA);
            push_item(len);
            push_item(8'($urandom));
            push_item(8'($urandom));
            for (int k = 0; k < $urandom_range(len - 1); k++)
                push_item(8'($urandom));
        end
    endtask

    task automatic push_random_run(input int unsigned count);
        int unsigned goal;
        goal = queued_items + count;
        while (queued_items < goal)
            push_random_sequence();
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (tx_bytes.size() != 0 || s_valid || due_results.size() != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct = 12;
        stall_pct = 80;
        push_item(8'hFF);
        push_data_frame(8'd1, 16'hFFFF, 1'b1);
        push_item(ufr_pkg::BYTE_START);
        push_item(ufr_pkg::BYTE_START);
        push_data_frame(8'd0, 16'h0000, 1'b1);
        push_data_frame(8'd2, 16'hA55A, 1'b0);
        push_word_frame(ufr_pkg::HDR_CRC, 1'b1);
        push_word_frame(ufr_pkg::HDR_LEN, 1'b0);
        push_word_frame(ufr_pkg::HDR_FRAMES, 1'b1);
        push_item(ufr_pkg::BYTE_END);
        push_random_run(150);
        wait_drained();

        gap_pct = 0;
        stall_pct = 0;
        hold_asks++;
        push_item(ufr_pkg::BYTE_START);
        push_data_frame(8'd20, 16'($urandom), 1'b1);
        push_word_frame(ufr_pkg::HDR_CRC, 1'b1);
        push_data_frame(8'd6, 16'($urandom), 1'b1);
        wait_drained();

        gap_pct = 80;
        stall_pct = 12;
        push_random_run(180);
        wait_drained();

        gap_pct = 0;
        stall_pct = 0;
        while (rx_phase != ufr_pkg::PH_HEADER) begin
            push_item(8'h5A);
            wait_drained();
        end
        push_item(ufr_pkg::BYTE_START);
        push_data_frame(8'd255, 16'($urandom), 1'b1);
        push_random_run(40);
        wait_drained();
        while (rx_phase != ufr_pkg::PH_HEADER) begin
            push_item(8'h5A);
            wait_drained();
        end
        push_item(ufr_pkg::BYTE_START);
        push_data_frame(8'd3, 16'($urandom), 1'b0);
        push_item(ufr_pkg::BYTE_END);
        push_random_run(20);
        wait_drained();

        repeat (8) @(negedge i_clk);
        $display("Sent %0d bytes and checked %0d results, %0d data frames acknowledged.",
                 bytes_sent, results_checked, acked_frames);
        $display("Runs included long frames, word frames, bad checksums and stalls.");
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failures, %0d results outstanding.", fail_count,
                     due_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
